[hw/rtl/sbsm_pkg.sv]
// ----------------------------------------------------------------------------
// sbsm_pkg: shared types and constants of the serial bank switch mapper
// Holds the access kinds, memory targets, register selects and the state
// and configuration structures that travel between the mapper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sbsm_pkg;

	// Geometry
	localparam int PRG_BANK_BYTES = 16384;
	localparam int CHR_BANK_BYTES = 4096;
	localparam int PRG_OFS_W      = $clog2(PRG_BANK_BYTES);
	localparam int CHR_OFS_W      = $clog2(CHR_BANK_BYTES);
	localparam int PHYS_W         = 18;
	localparam int ADDR_W         = 16;
	localparam int DATA_W         = 8;
	localparam int BANK_REG_W     = 5;
	localparam int PRG_SEL_W      = 4;
	localparam int CHR_BANK_W     = 5;
	localparam int RAM_OFS_W      = 13;

	// Access kinds carried on the input side
	typedef enum logic [1:0] {
		FUNC_CPU_RD = 2'd0,
		FUNC_CPU_WR = 2'd1,
		FUNC_PPU_RD = 2'd2,
		FUNC_PPU_WR = 2'd3
	} func_t;

	// Memory selected by one access
	typedef enum logic [1:0] {
		TGT_NONE    = 2'd0,
		TGT_PRG_ROM = 2'd1,
		TGT_PRG_RAM = 2'd2,
		TGT_CHR     = 2'd3
	} target_t;

	// Serial register chosen by address bits 14..13 on commit
	typedef enum logic [1:0] {
		SEL_CONTROL = 2'd0,
		SEL_CHR0    = 2'd1,
		SEL_CHR1    = 2'd2,
		SEL_PRG     = 2'd3
	} reg_sel_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_PRG_LAST_BANK   = 2'd0;
	localparam logic [1:0] CFG_PRG_RAM_PRESENT = 2'd1;
	localparam logic [1:0] CFG_INIT_MIRRORING  = 2'd2;
	localparam int         CFG_DATA_W          = 4;

	// Reset values
	localparam logic [3:0]            PRG_LAST_BANK_RST = 4'd15;
	localparam logic                  RAM_PRESENT_RST   = 1'b1;
	localparam logic [1:0]            INIT_MIRR_RST     = 2'd2;
	localparam logic [BANK_REG_W-1:0] CONTROL_RST       = 5'h0C;
	localparam logic [BANK_REG_W-1:0] CHR_HIGH_RST      = 5'd1;
	localparam logic [BANK_REG_W-1:0] PRG_MODE3_MASK    = 5'h0C;

	// Last serial bit position
	localparam logic [2:0] SHIFT_LAST = 3'd4;

	typedef struct packed {
		logic [3:0] prg_last_bank;
		logic       prg_ram_present;
		logic [1:0] initial_mirroring;
	} cfg_t;

	typedef struct packed {
		logic [BANK_REG_W-1:0] control;
		logic [BANK_REG_W-1:0] chr_low;
		logic [BANK_REG_W-1:0] chr_high;
		logic [BANK_REG_W-1:0] prg_bank;
		logic [ADDR_W-1:0]     prev_pc;
	} map_state_t;

	typedef struct packed {
		logic              mapped;
		target_t           target;
		logic [PHYS_W-1:0] phys_addr;
		logic              mem_write;
	} xlate_t;

endpackage

`default_nettype wire

[hw/rtl/serial_bank_switch_mapper_core.sv]
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_core: serial bank switch mapper top level
// Input register, translation and serial register update, result register.
// ----------------------------------------------------------------------------
// One access goes in per clock while s_tready is high. An accepted access is
// held in the input register, where it is decoded and the bank registers are
// updated, and its result is then presented in the result register. The
// result register and the input register advance together whenever the
// result is free or taken; a stall on the result side holds the result, and
// once the input register is full as well s_tready drops. Configuration
// writes take effect on the next clock and belong to idle periods. Mirroring
// in each result reflects the state after that access.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_bank_switch_mapper_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input accesses
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// bus_addr[15:0], wr_data[23:16], instr_pc[39:24]
	input  logic [39:0]                     s_tdata,
	input  logic [1:0]                      s_tuser,  // func[1:0]
	// Results
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// mapped[0], target[2:1], phys_addr[20:3], mem_write[21], mirroring[23:22]
	output logic [23:0]                     m_tdata,
	// Configuration
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [sbsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import sbsm_pkg::*;

	cfg_t              cfg_q;
	logic              valid_s1;
	func_t             func_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] data_s1;
	logic [ADDR_W-1:0] pc_s1;
	logic              valid_s2;
	xlate_t            res_s2;
	logic [1:0]        mirr_s2;

	logic              advance;
	logic              reg_wr_req;
	xlate_t            res;
	map_state_t        st;
	logic [1:0]        mirr_next;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{prg_last_bank: PRG_LAST_BANK_RST, prg_ram_present: RAM_PRESENT_RST,
				initial_mirroring: INIT_MIRR_RST};
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRG_LAST_BANK:   cfg_q.prg_last_bank     <= cfg_wdata[3:0];
				CFG_PRG_RAM_PRESENT: cfg_q.prg_ram_present   <= cfg_wdata[0];
				CFG_INIT_MIRRORING:  cfg_q.initial_mirroring <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// Advance both stages when the result slot is free or taken
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1 <= func_t'(s_tuser);
			addr_s1 <= s_tdata[15:0];
			data_s1 <= s_tdata[23:16];
			pc_s1   <= s_tdata[39:24];
		end
	end

	sbsm_xlate u_xlate (
		.func     (func_s1),
		.bus_addr (addr_s1),
		.instr_pc (pc_s1),
		.cfg      (cfg_q),
		.st       (st),
		.res      (res),
		.reg_wr   (reg_wr_req)
	);

	sbsm_serial u_serial (
		.clk               (clk),
		.arst_n            (arst_n),
		.wr_en             (valid_s1 && advance && reg_wr_req),
		.bus_addr          (addr_s1),
		.wr_data           (data_s1),
		.instr_pc          (pc_s1),
		.initial_mirroring (cfg_q.initial_mirroring),
		.st                (st),
		.mirroring_next    (mirr_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2  <= res;
			mirr_s2 <= mirr_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {mirr_s2, res_s2.mem_write, res_s2.phys_addr, res_s2.target,
		res_s2.mapped};

endmodule

`default_nettype wire

[hw/rtl/sbsm_xlate.sv]
// ----------------------------------------------------------------------------
// sbsm_xlate: access decode and address translation
// Decodes one bus access against the current bank registers and produces
// the target memory, physical address and the serial register write request.
// ----------------------------------------------------------------------------
`default_nettype none

module sbsm_xlate (
	input  sbsm_pkg::func_t              func,
	input  logic [sbsm_pkg::ADDR_W-1:0]  bus_addr,
	input  logic [sbsm_pkg::ADDR_W-1:0]  instr_pc,
	input  sbsm_pkg::cfg_t               cfg,
	input  sbsm_pkg::map_state_t         st,
	output sbsm_pkg::xlate_t             res,
	output logic                         reg_wr
);
	import sbsm_pkg::*;

	logic                 prg_upper;
	logic [PRG_SEL_W-1:0] prg_sel;
	logic [PRG_SEL_W-1:0] prg_bank;
	logic [PHYS_W-1:0]    prg_phys;
	logic                 chr_upper;
	logic [CHR_BANK_W-1:0] chr_bank;
	logic [PHYS_W-1:0]    chr_phys;
	logic                 ram_en;
	logic                 in_ram;
	logic                 in_rom;
	logic                 in_chr;

	// Select the 16KB PRG bank by PRG mode
	always_comb begin
		prg_upper = bus_addr[PRG_OFS_W];
		prg_sel   = st.prg_bank[PRG_SEL_W-1:0];
		case (st.control[3:2])
			2'd2:    prg_bank = prg_upper ? prg_sel : '0;
			2'd3:    prg_bank = prg_upper ? cfg.prg_last_bank : prg_sel;
			default: prg_bank = {prg_sel[PRG_SEL_W-1:1], prg_upper};
		endcase
		prg_phys = {prg_bank & cfg.prg_last_bank, bus_addr[PRG_OFS_W-1:0]};
	end

	// Select the 4KB CHR bank by CHR mode
	always_comb begin
		chr_upper = bus_addr[CHR_OFS_W];
		if (!st.control[4]) begin
			chr_bank = {st.chr_low[CHR_BANK_W-1:1], chr_upper};
		end else begin
			chr_bank = chr_upper ? st.chr_high : st.chr_low;
		end
		chr_phys = {1'b0, chr_bank, bus_addr[CHR_OFS_W-1:0]};
	end

	// Decode the access
	always_comb begin
		ram_en = cfg.prg_ram_present && !st.prg_bank[4];
		in_ram = (bus_addr[15:13] == 3'b011);
		in_rom = bus_addr[15];
		in_chr = (bus_addr[15:13] == 3'b000);
		res    = '{mapped: 1'b0, target: TGT_NONE, phys_addr: '0, mem_write: 1'b0};
		reg_wr = 1'b0;
		unique case (func)
			FUNC_CPU_RD, FUNC_CPU_WR: begin
				if (in_ram) begin
					if (ram_en) begin
						res.mapped    = 1'b1;
						res.target    = TGT_PRG_RAM;
						res.phys_addr = {{(PHYS_W-RAM_OFS_W){1'b0}}, bus_addr[RAM_OFS_W-1:0]};
						res.mem_write = (func == FUNC_CPU_WR);
					end
				end else if (in_rom) begin
					if (func == FUNC_CPU_RD) begin
						res.mapped    = 1'b1;
						res.target    = TGT_PRG_ROM;
						res.phys_addr = prg_phys;
					end else if (instr_pc != st.prev_pc) begin
						res.mapped = 1'b1;
						reg_wr     = 1'b1;
					end
				end
			end
			FUNC_PPU_RD, FUNC_PPU_WR: begin
				if (in_chr) begin
					res.mapped    = 1'b1;
					res.target    = TGT_CHR;
					res.phys_addr = chr_phys;
					res.mem_write = (func == FUNC_PPU_WR);
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/sbsm_serial.sv]
// ----------------------------------------------------------------------------
// sbsm_serial: serial load shift register and bank registers
// Collects five data bits one write at a time, commits them to the control,
// CHR or PRG register and tracks the mirroring in force.
// ----------------------------------------------------------------------------
`default_nettype none

module sbsm_serial (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [sbsm_pkg::ADDR_W-1:0]  bus_addr,
	input  logic [sbsm_pkg::DATA_W-1:0]  wr_data,
	input  logic [sbsm_pkg::ADDR_W-1:0]  instr_pc,
	input  logic [1:0]                   initial_mirroring,
	output sbsm_pkg::map_state_t         st,
	output logic [1:0]                   mirroring_next
);
	import sbsm_pkg::*;

	logic [BANK_REG_W-1:0] shift_q;
	logic [2:0]            count_q;
	logic                  ctrl_written_q;
	map_state_t            st_q;

	logic [BANK_REG_W-1:0] shift_d;
	logic [2:0]            count_d;
	logic                  ctrl_written_d;
	map_state_t            st_d;
	logic [BANK_REG_W-1:0] shifted;

	// Compute next register contents for one serial write
	always_comb begin
		shift_d        = shift_q;
		count_d        = count_q;
		ctrl_written_d = ctrl_written_q;
		st_d           = st_q;
		shifted        = {wr_data[0], shift_q[BANK_REG_W-1:1]};
		if (wr_en) begin
			st_d.prev_pc = instr_pc;
			if (wr_data[7]) begin
				shift_d        = '0;
				count_d        = '0;
				st_d.control   = st_q.control | PRG_MODE3_MASK;
				ctrl_written_d = 1'b1;
			end else if (count_q != SHIFT_LAST) begin
				shift_d = shifted;
				count_d = count_q + 3'd1;
			end else begin
				shift_d = '0;
				count_d = '0;
				unique case (reg_sel_t'(bus_addr[14:13]))
					SEL_CONTROL: begin
						st_d.control   = shifted;
						ctrl_written_d = 1'b1;
					end
					SEL_CHR0: st_d.chr_low  = shifted;
					SEL_CHR1: st_d.chr_high = shifted;
					SEL_PRG:  st_d.prg_bank = shifted;
					default: ;
				endcase
			end
		end
	end

	// Hold state between writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q        <= '0;
			count_q        <= '0;
			ctrl_written_q <= 1'b0;
			st_q           <= '{control: CONTROL_RST, chr_low: '0, chr_high: CHR_HIGH_RST,
				prg_bank: '0, prev_pc: '0};
		end else begin
			shift_q        <= shift_d;
			count_q        <= count_d;
			ctrl_written_q <= ctrl_written_d;
			st_q           <= st_d;
		end
	end

	assign st             = st_q;
	assign mirroring_next = ctrl_written_d ? st_d.control[1:0] : initial_mirroring;

endmodule

`default_nettype wire

[tb/serial_bank_switch_mapper_core_test.sv]
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_core_test: self-checking bench for the mapper core
// Drives CPU and PPU bus accesses over the input stream, predicts each
// translated result in a scoreboard that tracks the serial bank registers,
// and compares every result transfer field by field. Runs several
// configuration settings with bursty input, receiver stalls and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_bank_switch_mapper_core_test;
	import sbsm_pkg::*;

	// Bus map boundaries
	localparam logic [15:0] RAM_BASE  = 16'h6000;
	localparam logic [15:0] ROM_BASE  = 16'h8000;
	localparam logic [15:0] ROM_UPPER = 16'hC000;
	localparam logic [15:0] PPU_TOP   = 16'h2000;

	// PRG banking modes from control bits 3..2
	localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
	localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

	// Receiver stall patterns
	localparam int RX_ALWAYS  = 0;
	localparam int RX_RANDOM  = 1;
	localparam int RX_PATTERN = 2;
	localparam int RX_COIN    = 3;

	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic        mapped;
		target_t     target;
		logic [17:0] phys_addr;
		logic        mem_write;
		logic [1:0]  mirroring;
	} access_result_t;

	// Predicts mapper results and checks them in order
	class mapper_scoreboard;
		logic [3:0]  last_bank;
		logic        ram_present;
		logic [1:0]  init_mirr;
		logic [4:0]  shift_bits;
		logic [2:0]  bit_cnt;
		logic [4:0]  control;
		logic [4:0]  chr_low;
		logic [4:0]  chr_high;
		logic [4:0]  prg_bank;
		logic [15:0] prev_pc;
		logic        control_written;
		access_result_t expected_results[$];
		int errors;

		function new();
			last_bank       = 4'd15;
			ram_present     = 1'b1;
			init_mirr       = 2'd2;
			shift_bits      = '0;
			bit_cnt         = '0;
			control         = 5'h0C;
			chr_low         = '0;
			chr_high        = 5'd1;
			prg_bank        = '0;
			prev_pc         = '0;
			control_written = 1'b0;
			errors          = 0;
		endfunction

		function void set_config(logic [1:0] idx, logic [3:0] v);
			case (idx)
				CFG_PRG_LAST_BANK:   last_bank = v;
				CFG_PRG_RAM_PRESENT: ram_present = v[0];
				CFG_INIT_MIRRORING:  init_mirr = v[1:0];
				default: ;
			endcase
		endfunction

		function logic [17:0] prg_rom_addr(logic [15:0] a);
			logic [3:0] bank;
			logic       upper;
			upper = (a >= ROM_UPPER);
			case (control[3:2])
				PRG_MODE_FIX_LOW:  bank = upper ? prg_bank[3:0] : 4'd0;
				PRG_MODE_FIX_HIGH: bank = upper ? last_bank : prg_bank[3:0];
				// 32KB modes: pair of banks, low bit from the address
				default:           bank = {prg_bank[3:1], upper};
			endcase
			bank &= last_bank;
			return {bank, a[13:0]};
		endfunction

		function logic [17:0] chr_addr(logic [15:0] a);
			logic [4:0] bank;
			if (!control[4])
				bank = {chr_low[4:1], a[12]};
			else
				bank = a[12] ? chr_high : chr_low;
			return {1'b0, bank, a[11:0]};
		endfunction

		// Shift one serial bit in, commit on the fifth
		function void shift_in(logic [15:0] a, logic [7:0] d);
			logic [4:0] val;
			if (d[7]) begin
				shift_bits      = '0;
				bit_cnt         = '0;
				control         = control | 5'h0C;
				control_written = 1'b1;
				return;
			end
			shift_bits = {d[0], shift_bits[4:1]};
			if (bit_cnt < 3'd4) begin
				bit_cnt++;
				return;
			end
			val        = shift_bits;
			shift_bits = '0;
			bit_cnt    = '0;
			case (reg_sel_t'(a[14:13]))
				SEL_CONTROL: begin
					control         = val;
					control_written = 1'b1;
				end
				SEL_CHR0: chr_low = val;
				SEL_CHR1: chr_high = val;
				default:  prg_bank = val;
			endcase
		endfunction

		function void note_access(func_t f, logic [15:0] a, logic [7:0] d, logic [15:0] pc);
			access_result_t r;
			r = '0;
			r.target = TGT_NONE;
			if (f == FUNC_CPU_RD || f == FUNC_CPU_WR) begin
				if (a >= RAM_BASE && a < ROM_BASE) begin
					if (ram_present && !prg_bank[4]) begin
						r.mapped    = 1'b1;
						r.target    = TGT_PRG_RAM;
						r.phys_addr = {5'd0, a[12:0]};
						r.mem_write = (f == FUNC_CPU_WR);
					end
				end else if (a >= ROM_BASE) begin
					if (f == FUNC_CPU_RD) begin
						r.mapped    = 1'b1;
						r.target    = TGT_PRG_ROM;
						r.phys_addr = prg_rom_addr(a);
					end else if (pc != prev_pc) begin
						r.mapped = 1'b1;
						prev_pc  = pc;
						shift_in(a, d);
					end
				end
			end else if (a < PPU_TOP) begin
				r.mapped    = 1'b1;
				r.target    = TGT_CHR;
				r.phys_addr = chr_addr(a);
				r.mem_write = (f == FUNC_PPU_WR);
			end
			r.mirroring = control_written ? control[1:0] : init_mirr;
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [23:0] m);
			access_result_t got;
			access_result_t want;
			got.mapped    = m[0];
			got.target    = target_t'(m[2:1]);
			got.phys_addr = m[20:3];
			got.mem_write = m[21];
			got.mirroring = m[23:22];
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result transfer %h", m);
				return;
			end
			want = expected_results.pop_front();
			if (got.mapped !== want.mapped || got.target !== want.target ||
			    got.phys_addr !== want.phys_addr || got.mem_write !== want.mem_write ||
			    got.mirroring !== want.mirroring) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch at %0t: expected map=%0d tgt=%0d phys=%h wr=%0d",
					          " mir=%0d, got map=%0d tgt=%0d phys=%h wr=%0d mir=%0d"},
					         $realtime, want.mapped, want.target, want.phys_addr,
					         want.mem_write, want.mirroring, got.mapped, got.target,
					         got.phys_addr, got.mem_write, got.mirroring);
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	mapper_scoreboard sb;
	int burst_left;
	int items_sent;
	bit sender_bursty;
	int rx_mode;
	bit hold_req;

	serial_bank_switch_mapper_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on run time
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: stall on the selected pattern, hold off on request
	initial begin
		int hold_left;
		int tick;
		hold_left = 0;
		tick      = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS:  m_tready = 1'b1;
					RX_RANDOM:  m_tready = ($urandom_range(0, 3) != 0);
					RX_PATTERN: m_tready = ((tick % 11) < 6);
					default:    m_tready = $urandom_range(0, 1);
				endcase
			end
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// Offer one access, with a random gap between bursts, and note it on transfer
	task automatic send_access(func_t f, logic [15:0] a, logic [7:0] d, logic [15:0] pc);
		int gap;
		if (sender_bursty && burst_left <= 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = {pc, d, a};
		s_tuser  = f;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_access(f, a, d, pc);
		items_sent++;
		burst_left--;
	endtask

	// Register write from a fresh instruction PC
	task automatic cpu_write(logic [15:0] a, logic [7:0] d);
		logic [15:0] pc;
		pc = 16'($urandom);
		if (pc == sb.prev_pc)
			pc = pc + 16'd1;
		send_access(FUNC_CPU_WR, a, d, pc);
	endtask

	task automatic random_read();
		case ($urandom_range(0, 3))
			0: send_access(FUNC_CPU_RD, 16'($urandom), 8'($urandom), 16'($urandom));
			1: send_access(FUNC_CPU_RD, ROM_BASE | 16'($urandom_range(0, 16'h7FFF)),
			               8'($urandom), 16'($urandom));
			2: send_access(FUNC_PPU_RD, 16'($urandom_range(0, 16'h1FFF)), 8'($urandom),
			               16'($urandom));
			default: send_access(func_t'($urandom_range(2, 3)), 16'($urandom), 8'($urandom),
			                     16'($urandom));
		endcase
	endtask

	// Load a 5-bit value serially, low bit first, optionally mixing in reads
	task automatic load_serial(logic [15:0] a, logic [4:0] v, bit mix);
		for (int i = 0; i < 5; i++) begin
			if (mix && $urandom_range(0, 3) == 0)
				random_read();
			cpu_write(a, {1'b0, 6'($urandom), v[i]});
		end
	endtask

	// Stop offering and wait for every expected result
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [3:0] v);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_config(idx, v);
	endtask

	task automatic set_mode(logic [3:0] last, logic ram, logic [1:0] mirr);
		drain();
		write_cfg(CFG_PRG_LAST_BANK, last);
		write_cfg(CFG_PRG_RAM_PRESENT, {3'd0, ram});
		write_cfg(CFG_INIT_MIRRORING, {2'd0, mirr});
	endtask

	// Mostly serial loads and reads, with noise and broken sequences
	task automatic run_random(int n);
		int stop;
		int r;
		stop = items_sent + n;
		while (items_sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				load_serial(ROM_BASE | 16'($urandom_range(0, 16'h7FFF)), 5'($urandom), 1'b1);
			end else if (r < 70) begin
				random_read();
			end else if (r < 80) begin
				send_access(func_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
				            16'($urandom));
			end else if (r < 85) begin
				cpu_write(ROM_BASE | 16'($urandom_range(0, 16'h7FFF)), 8'h80 | 8'($urandom));
			end else if (r < 90) begin
				// repeated PC: ignored by the mapper
				send_access(FUNC_CPU_WR, ROM_BASE | 16'($urandom_range(0, 16'h7FFF)),
				            8'($urandom), sb.prev_pc);
			end else begin
				send_access(FUNC_CPU_WR, RAM_BASE | 16'($urandom_range(0, 16'h1FFF)),
				            8'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		sb            = new();
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = FUNC_CPU_RD;
		cfg_we        = 1'b0;
		cfg_index     = CFG_PRG_LAST_BANK;
		cfg_wdata     = '0;
		burst_left    = 0;
		items_sent    = 0;
		sender_bursty = 1'b0;
		rx_mode       = RX_ALWAYS;
		hold_req      = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: repeated PC against the reset PC, map edges, reset bit, commits
		send_access(FUNC_CPU_WR, ROM_BASE, 8'h01, 16'h0000);
		send_access(FUNC_CPU_RD, 16'h0000, 8'h00, 16'h0000);
		send_access(FUNC_CPU_RD, 16'h5FFF, 8'h00, 16'hFFFF);
		send_access(FUNC_CPU_RD, RAM_BASE, 8'h00, 16'h0001);
		send_access(FUNC_CPU_WR, 16'h7FFF, 8'hFF, 16'h0002);
		send_access(FUNC_CPU_RD, ROM_BASE, 8'h00, 16'h0003);
		send_access(FUNC_CPU_RD, 16'hBFFF, 8'h00, 16'h0004);
		send_access(FUNC_CPU_RD, ROM_UPPER, 8'h00, 16'h0005);
		send_access(FUNC_CPU_RD, 16'hFFFF, 8'h00, 16'h0006);
		send_access(FUNC_PPU_RD, 16'h0000, 8'h00, 16'h0007);
		send_access(FUNC_PPU_RD, 16'h1FFF, 8'h00, 16'h0008);
		send_access(FUNC_PPU_WR, 16'h1000, 8'hA5, 16'h0009);
		send_access(FUNC_PPU_RD, PPU_TOP, 8'h00, 16'h000A);
		send_access(FUNC_PPU_WR, 16'hFFFF, 8'hFF, 16'h000B);
		send_access(FUNC_CPU_WR, 16'hFFFF, 8'h80, 16'h1234);
		send_access(FUNC_CPU_WR, ROM_BASE, 8'h01, 16'h1234);
		load_serial(ROM_BASE, 5'h1B, 1'b0);
		load_serial(16'hE000, 5'h1F, 1'b0);
		send_access(FUNC_CPU_RD, RAM_BASE, 8'h00, 16'h0010);
		send_access(FUNC_CPU_RD, ROM_UPPER, 8'h00, 16'h0011);

		// No idling on either side
		set_mode(4'd15, 1'b1, 2'd3);
		sender_bursty = 1'b0;
		rx_mode       = RX_ALWAYS;
		run_random(105);

		// Smallest ROM, no RAM
		set_mode(4'd0, 1'b0, 2'd0);
		sender_bursty = 1'b1;
		rx_mode       = RX_RANDOM;
		run_random(105);

		// Long receiver hold-off while the sender keeps offering
		set_mode(4'd7, 1'b1, 2'd1);
		rx_mode = RX_PATTERN;
		run_random(30);
		hold_req = 1'b1;
		run_random(75);

		// Sender pauses until all results are back, mid-phase
		set_mode(4'd15, 1'b0, 2'd2);
		rx_mode = RX_COIN;
		run_random(50);
		drain();
		run_random(55);

		set_mode(4'($urandom), 1'($urandom), 2'($urandom));
		rx_mode = RX_RANDOM;
		run_random(105);

		set_mode(4'd3, 1'b1, 2'd3);
		sender_bursty = 1'b0;
		rx_mode       = RX_PATTERN;
		run_random(105);

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
